// ===== src/rat_alu_pkg.sv =====
`timescale 1ns / 1ps
package rat_alu_pkg;

  typedef enum logic [2:0] {
    FuncLoad = 3'd0,
    FuncAdd  = 3'd1,
    FuncSub  = 3'd2,
    FuncMul  = 3'd3,
    FuncDiv  = 3'd4,
    FuncInc  = 3'd5,
    FuncDec  = 3'd6,
    FuncNop  = 3'd7
  } func_e;

  localparam int unsigned FuncBits = 3;
  localparam int unsigned FieldBits = 32;

endpackage

// ===== src/rat_alu_divider.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider on magnitudes, one quotient bit per cycle.
module rat_alu_divider #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] dividend_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] quot_o,
  output logic [WORD_BITS-1:0] rem_o
);

  localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

  logic               busy_q, busy_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [WORD_BITS-1:0] quot_q, quot_d, rem_q, rem_d, div_q, div_d;
  logic [WORD_BITS:0]   trial;
  logic                 done_q, done_d;

  assign trial = {rem_q, quot_q[WORD_BITS-1]} - {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntBits'(WORD_BITS);
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[WORD_BITS]) begin
        rem_d = {rem_q[WORD_BITS-2:0], quot_q[WORD_BITS-1]};
        quot_d = {quot_q[WORD_BITS-2:0], 1'b0};
      end else begin
        rem_d = trial[WORD_BITS-1:0];
        quot_d = {quot_q[WORD_BITS-2:0], 1'b1};
      end
      cnt_d = cnt_q - CntBits'(1);
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/rational_accumulator_alu_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Bits  Fields (lowest bit first)
// s_axis   in   67    tdata: operand_num[31:0], operand_den[63:32]; tuser: func[2:0]
// m_axis   out  129   tdata: new_num, new_den, old_num, old_den; tuser: zero_den_error
// An item runs Euclid remainder steps and then two final divisions, all on the one shared
// radix-2 divider; Load, Nop and a zero denominator skip them. Products use one multiplier,
// stepped through StMul0, StMul1 and, for add and subtract, StMul2; Inc and Dec use none.
// Reset sets the held value to 1/1. The input is not ready while an item is in work;
// a finished item waits until the output register is free before it is written there.
module rational_accumulator_alu_unit #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,   // operand_num, operand_den
  input  logic [2:0]   s_axis_tuser,   // func
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // new_num, new_den, old_num, old_den
  output logic         m_axis_tuser    // zero_den_error
);

  localparam int unsigned W = WORD_BITS;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StMul0  = 9'b000000010,
    StMul1  = 9'b000000100,
    StMul2  = 9'b000001000,
    StCheck = 9'b000010000,
    StGcd   = 9'b000100000,
    StDivN  = 9'b001000000,
    StDivM  = 9'b010000000,
    StOut   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic [W-1:0] a_q, b_q, c_q, d_q, n_q, m_q, x_q, y_q, p_q, g_q;
  logic [W-1:0] a_d, b_d, c_d, d_d, n_d, m_d, x_d, y_d, p_d, g_d;
  rat_alu_pkg::func_e func_q, func_d;
  logic         err_q, err_d, ovld_q, ovld_d, wait_q, wait_d;
  logic [127:0] odata_q, odata_d;
  logic         oerr_q, oerr_d;

  logic [W-1:0] mul_a, mul_b, mul_p, div_n, div_d_s, div_q_s, div_r_s;
  logic [W-1:0] st_n, st_d;
  logic [2*W-1:0] mul_full;
  logic         div_start, div_done;
  logic [W-1:0] div_quot, div_rem;
  logic         neg_n, neg_d;

  assign mul_full = mul_a * mul_b;
  assign mul_p = mul_full[W-1:0];

  function automatic logic [W-1:0] wrap_in(input logic [31:0] v);
    return W'({{32{v[31]}}, v});
  endfunction

  function automatic logic [31:0] wrap_out(input logic [W-1:0] v);
    return 32'({{32{v[W-1]}}, v});
  endfunction

  function automatic logic [W-1:0] absw(input logic [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  rat_alu_divider #(.WORD_BITS(W)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(absw(st_n)), .divisor_i(absw(st_d)),
    .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  assign neg_n = div_n[W-1];
  assign neg_d = div_d_s[W-1];
  assign div_q_s = (neg_n != neg_d) ? -div_quot : div_quot;
  assign div_r_s = neg_n ? -div_rem : div_rem;

  always_comb begin
    mul_a = a_q;
    mul_b = d_q;
    unique case (state_q)
      StMul0: begin
        mul_a = (func_q == rat_alu_pkg::FuncMul) ? a_q : a_q;
        mul_b = (func_q == rat_alu_pkg::FuncMul) ? c_q : d_q;
      end
      StMul1: begin
        mul_a = b_q;
        mul_b = (func_q == rat_alu_pkg::FuncDiv) ? c_q : d_q;
      end
      StMul2: begin
        mul_a = c_q;
        mul_b = b_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    div_n = x_q;
    div_d_s = y_q;
    if (state_q == StDivN) begin
      div_n = n_q;
      div_d_s = g_q;
    end else if (state_q == StDivM) begin
      div_n = m_q;
      div_d_s = g_q;
    end
  end

  always_comb begin
    st_n = x_q;
    st_d = y_q;
    if (state_q == StCheck) begin
      st_n = n_q;
      st_d = m_q;
    end else if (state_q == StGcd) begin
      if (div_r_s == '0) begin
        st_n = n_q;
        st_d = y_q;
      end else begin
        st_n = y_q;
        st_d = div_r_s;
      end
    end else if (state_q == StDivN) begin
      st_n = m_q;
      st_d = g_q;
    end
  end

  always_comb begin
    state_d = state_q;
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; n_d = n_q; m_d = m_q;
    x_d = x_q; y_d = y_q; p_d = p_q; g_d = g_q; func_d = func_q;
    err_d = err_q; ovld_d = ovld_q; wait_d = wait_q;
    odata_d = odata_q; oerr_d = oerr_q;
    div_start = 1'b0;
    if (ovld_q && m_axis_tready) ovld_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          func_d = rat_alu_pkg::func_e'(s_axis_tuser);
          c_d = wrap_in(s_axis_tdata[31:0]);
          d_d = wrap_in(s_axis_tdata[63:32]);
          err_d = 1'b0;
          unique case (rat_alu_pkg::func_e'(s_axis_tuser))
            rat_alu_pkg::FuncLoad: begin
              n_d = wrap_in(s_axis_tdata[31:0]);
              m_d = wrap_in(s_axis_tdata[63:32]);
              state_d = StCheck;
            end
            rat_alu_pkg::FuncInc: begin
              n_d = a_q + b_q; m_d = b_q; state_d = StCheck;
            end
            rat_alu_pkg::FuncDec: begin
              n_d = a_q - b_q; m_d = b_q; state_d = StCheck;
            end
            rat_alu_pkg::FuncNop: begin
              n_d = a_q; m_d = b_q; state_d = StCheck;
            end
            default: state_d = StMul0;
          endcase
        end
      end
      StMul0: begin
        p_d = mul_p;
        state_d = StMul1;
      end
      StMul1: begin
        m_d = mul_p;
        if (func_q == rat_alu_pkg::FuncAdd || func_q == rat_alu_pkg::FuncSub) begin
          state_d = StMul2;
        end else begin
          n_d = p_q;
          state_d = StCheck;
        end
      end
      StMul2: begin
        n_d = (func_q == rat_alu_pkg::FuncAdd) ? p_q + mul_p : p_q - mul_p;
        state_d = StCheck;
      end
      StCheck: begin
        if (m_q == '0) begin
          err_d = 1'b1; n_d = a_q; m_d = b_q;
          state_d = StOut;
        end else if (func_q == rat_alu_pkg::FuncLoad || func_q == rat_alu_pkg::FuncNop) begin
          state_d = StOut;
        end else begin
          x_d = n_q; y_d = m_q;
          div_start = 1'b1; wait_d = 1'b1;
          state_d = StGcd;
        end
      end
      StGcd: begin
        if (div_done) begin
          if (div_r_s == '0) begin
            g_d = y_q;
            div_start = 1'b1;
            state_d = StDivN;
          end else begin
            x_d = y_q; y_d = div_r_s;
            div_start = 1'b1;
          end
        end
      end
      StDivN: begin
        if (div_done) begin
          n_d = div_q_s;
          div_start = 1'b1;
          state_d = StDivM;
        end
      end
      StDivM: begin
        if (div_done) begin
          m_d = div_q_s;
          wait_d = 1'b0;
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ovld_q) begin
          odata_d = {wrap_out(b_q), wrap_out(a_q), wrap_out(m_q), wrap_out(n_q)};
          oerr_d = err_q;
          ovld_d = 1'b1;
          a_d = n_q; b_d = m_q;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      a_q <= W'(1);
      b_q <= W'(1);
      ovld_q <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q <= a_d;
      b_q <= b_d;
      ovld_q <= ovld_d;
      wait_q <= wait_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d; d_q <= d_d; n_q <= n_d; m_q <= m_d;
    x_q <= x_d; y_q <= y_d; p_q <= p_d; g_q <= g_d;
    func_q <= func_d; err_q <= err_d;
    odata_q <= odata_d; oerr_q <= oerr_d;
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = oerr_q;

  // The divider runs only while the sequencer is in a division phase.
  a_div_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> wait_q)
    else $error("divider finished outside a division phase");

  // Held denominator is never zero once a result has been produced.
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (b_q != '0))
    else $error("held denominator is zero");

  // A result leaves the output register only after a transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovld_q && !m_axis_tready) |=> ovld_q)
    else $error("result dropped without transfer");

endmodule
